>>> sv/limit_order_matching_engine_defines.svh
// Assertion macros used by the checker file of the matching engine.
`ifndef LIMIT_ORDER_MATCHING_ENGINE_DEFINES_SVH
`define LIMIT_ORDER_MATCHING_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define LOME_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define LOME_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/lome_pkg.sv
// Types and constants shared by the matching engine modules.
`default_nettype none
package lome_pkg;

  localparam int ID_W    = 32;
  localparam int QTY_W   = 32;
  localparam int PRICE_W = 8;
  localparam int SLOT_W  = 6;
  localparam int TOT_W   = 38;
  localparam int SUM_W   = 46;

  localparam logic [1:0] EXEC_GTC = 2'd0;
  localparam logic [1:0] EXEC_IOC = 2'd1;
  localparam logic [1:0] EXEC_FOK = 2'd2;

  typedef enum logic [2:0] {
    KIND_FILL     = 3'd0,
    KIND_RESTED   = 3'd1,
    KIND_DONE     = 3'd2,
    KIND_KILLED   = 3'd3,
    KIND_REJECTED = 3'd4,
    KIND_FULL     = 3'd5
  } kind_t;

  typedef struct packed {
    logic  in_rdy;
    logic  ptr_init_fok;
    logic  ptr_init_match;
    logic  ptr_step;
    logic  fok_scan;
    logic  hold_lvl;
    logic  do_fill;
    logic  fptr_clr;
    logic  fptr_step;
    logic  rd_price;
    logic  rest_a;
    logic  rest_b;
    logic  emit_final;
    kind_t final_kind;
  } lome_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic reject;
    logic is_fok;
    logic is_gtc;
    logic rem_zero;
    logic fok_short;
    logic sc_hit;
    logic cross_ok;
    logic ptr_end;
    logic fill_done;
    logic free_hit;
    logic free_end;
    logic out_free;
  } lome_sts_t;

endpackage
`default_nettype wire

>>> sv/lome_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lome_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> sv/lome_ctrl.sv
// Sequencer of the matching engine: walks one order through check, match and rest.
`default_nettype none
module lome_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire lome_pkg::lome_sts_t  sts,
  output lome_pkg::lome_cmd_t       cmd
);
  import lome_pkg::*;

  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0000000000001,
    ST_CHECK  = 13'b0000000000010,
    ST_FOK    = 13'b0000000000100,
    ST_FOKW   = 13'b0000000001000,
    ST_FOKC   = 13'b0000000010000,
    ST_SCAN   = 13'b0000000100000,
    ST_HEAD   = 13'b0000001000000,
    ST_SLOT   = 13'b0000010000000,
    ST_END    = 13'b0000100000000,
    ST_FREE   = 13'b0001000000000,
    ST_REST_A = 13'b0010000000000,
    ST_REST_B = 13'b0100000000000,
    ST_FIN    = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  kind_t  kind_r, kind_nxt;

  always_comb begin
    cmd            = '0;
    cmd.final_kind = kind_r;
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    case (state_r)
      ST_IDLE: begin
        cmd.in_rdy = 1'b1;
        if (sts.in_valid) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.reject) begin
          kind_nxt  = KIND_REJECTED;
          state_nxt = ST_FIN;
        end else if (sts.is_fok) begin
          cmd.ptr_init_fok = 1'b1;
          state_nxt        = ST_FOK;
        end else begin
          cmd.ptr_init_match = 1'b1;
          state_nxt          = ST_SCAN;
        end
      end
      ST_FOK: begin
        cmd.fok_scan = 1'b1;
        if (sts.ptr_end) begin
          state_nxt = ST_FOKW;
        end else begin
          cmd.ptr_step = 1'b1;
        end
      end
      ST_FOKW: begin
        state_nxt = ST_FOKC;
      end
      ST_FOKC: begin
        if (sts.fok_short) begin
          kind_nxt  = KIND_KILLED;
          state_nxt = ST_FIN;
        end else begin
          cmd.ptr_init_match = 1'b1;
          state_nxt          = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.rem_zero) begin
          state_nxt = ST_END;
        end else if (sts.sc_hit) begin
          state_nxt = sts.cross_ok ? ST_HEAD : ST_END;
        end else if (sts.ptr_end) begin
          state_nxt = ST_END;
        end else begin
          cmd.ptr_step = 1'b1;
        end
      end
      ST_HEAD: begin
        cmd.hold_lvl = 1'b1;
        state_nxt    = ST_SLOT;
      end
      ST_SLOT: begin
        if (sts.out_free) begin
          cmd.do_fill = 1'b1;
          state_nxt   = sts.fill_done ? ST_END : ST_SCAN;
        end
      end
      ST_END: begin
        if (sts.is_gtc && !sts.rem_zero) begin
          cmd.fptr_clr = 1'b1;
          state_nxt    = ST_FREE;
        end else begin
          kind_nxt  = KIND_DONE;
          state_nxt = ST_FIN;
        end
      end
      ST_FREE: begin
        cmd.rd_price = 1'b1;
        if (sts.free_hit) begin
          state_nxt = ST_REST_A;
        end else if (sts.free_end) begin
          kind_nxt  = KIND_FULL;
          state_nxt = ST_FIN;
        end else begin
          cmd.fptr_step = 1'b1;
        end
      end
      ST_REST_A: begin
        cmd.rd_price = 1'b1;
        cmd.rest_a   = 1'b1;
        state_nxt    = ST_REST_B;
      end
      ST_REST_B: begin
        cmd.rd_price   = 1'b1;
        cmd.final_kind = KIND_RESTED;
        if (sts.out_free) begin
          cmd.rest_b     = 1'b1;
          cmd.emit_final = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.emit_final = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
  end
endmodule
`default_nettype wire

>>> sv/lome_dp.sv
// Datapath of the matching engine: order registers, book memories, occupancy and result register.
`default_nettype none
module lome_dp #(
  parameter int PRICE_LEVELS = 256,
  parameter int ORDER_SLOTS  = 63
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire lome_pkg::lome_cmd_t               cmd,
  output lome_pkg::lome_sts_t                    sts,
  input  wire logic                              in_valid,
  input  wire logic [lome_pkg::ID_W-1:0]         in_order_id,
  input  wire logic                              in_is_buy,
  input  wire logic                              in_is_limit,
  input  wire logic [1:0]                        in_exec_kind,
  input  wire logic [lome_pkg::PRICE_W-1:0]      in_price,
  input  wire logic [lome_pkg::QTY_W-1:0]        in_quantity,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [2:0]                             out_kind,
  output logic [lome_pkg::ID_W-1:0]              out_maker_id,
  output logic [lome_pkg::QTY_W-1:0]             out_fill_quantity,
  output logic [lome_pkg::PRICE_W-1:0]           out_fill_price,
  output logic [lome_pkg::QTY_W-1:0]             out_remaining,
  output logic                                   out_last
);
  import lome_pkg::*;

  localparam int NLEV = (PRICE_LEVELS < (1 << PRICE_W)) ? PRICE_LEVELS : (1 << PRICE_W);
  localparam int LW   = $clog2(NLEV);
  localparam int SAW  = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;

  // order registers
  logic [ID_W-1:0]    id_r, id_nxt;
  logic               buy_r, buy_nxt, lim_r, lim_nxt;
  logic [1:0]         exec_r, exec_nxt;
  logic [PRICE_W-1:0] price_r, price_nxt;
  logic [QTY_W-1:0]   rem_r, rem_nxt;
  // walk registers
  logic [LW-1:0]      ptr_r, ptr_nxt;
  logic               up_r, up_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic               qv_r, qv_nxt;
  logic [SLOT_W-1:0]  head_r, head_nxt, tail_r, tail_nxt;
  logic [TOT_W-1:0]   total_r, total_nxt;
  logic [SAW-1:0]     fptr_r, fptr_nxt;
  // book flags
  logic [NLEV-1:0]        occ_r, occ_nxt, side_r, side_nxt;
  logic [ORDER_SLOTS-1:0] free_r, free_nxt;
  // result register
  logic               ov_r, ov_nxt;
  kind_t              okind_r, okind_nxt;
  logic [ID_W-1:0]    omaker_r, omaker_nxt;
  logic [QTY_W-1:0]   oqty_r, oqty_nxt, orem_r, orem_nxt;
  logic [PRICE_W-1:0] oprice_r, oprice_nxt;
  logic               olast_r, olast_nxt;

  // memory ports
  logic [SLOT_W-1:0] head_q, tail_q, snext_q;
  logic [TOT_W-1:0]  total_q;
  logic [ID_W-1:0]   sid_q;
  logic [QTY_W-1:0]  srem_q;
  logic [LW-1:0]     lvl_raddr, lvl_waddr;
  logic [SAW-1:0]    slot_raddr, srem_waddr, snext_waddr;
  logic              head_we, tail_we, total_we, srem_we, snext_we;
  logic [SLOT_W-1:0] head_wdata, snext_wdata;
  logic [TOT_W-1:0]  total_wdata;
  logic [QTY_W-1:0]  srem_wdata;

  logic              accept, out_free, reach, qual, emptied, lvl_empty;
  logic [LW-1:0]     plev;
  logic [PRICE_W-1:0] ptr_ext;
  logic [QTY_W-1:0]  fq, srem_left;
  logic [SLOT_W-1:0] new_slot;
  logic [SAW-1:0]    head_idx;

  assign accept    = in_valid && cmd.in_rdy;
  assign out_free  = !ov_r || out_ready;
  assign plev      = price_r[LW-1:0];
  assign ptr_ext   = PRICE_W'(ptr_r);
  assign new_slot  = SLOT_W'(fptr_r);
  assign head_idx  = head_r[SAW-1:0];
  assign fq        = (rem_r < srem_q) ? rem_r : srem_q;
  assign srem_left = srem_q - fq;
  assign emptied   = (srem_left == '0);
  assign lvl_empty = emptied && (tail_r == head_r);
  assign reach     = !lim_r || (buy_r ? (ptr_ext <= price_r) : (ptr_ext >= price_r));
  assign qual      = occ_r[ptr_r] && (side_r[ptr_r] != buy_r) && reach;

  assign lvl_raddr  = cmd.rd_price ? plev : ptr_r;
  assign slot_raddr = cmd.hold_lvl ? head_q[SAW-1:0] : head_idx;
  assign lvl_waddr  = cmd.do_fill ? ptr_r : plev;

  assign head_we    = (cmd.do_fill && emptied && !lvl_empty) || (cmd.rest_b && !occ_r[plev]);
  assign head_wdata = cmd.do_fill ? snext_q : new_slot;
  assign tail_we    = cmd.rest_b;
  assign total_we   = cmd.do_fill || cmd.rest_b;
  always_comb begin
    if (cmd.do_fill) begin
      total_wdata = lvl_empty ? '0 : (total_r - TOT_W'(fq));
    end else if (occ_r[plev]) begin
      total_wdata = total_q + TOT_W'(rem_r);
    end else begin
      total_wdata = TOT_W'(rem_r);
    end
  end

  assign srem_we     = cmd.do_fill || cmd.rest_a;
  assign srem_waddr  = cmd.do_fill ? head_idx : fptr_r;
  assign srem_wdata  = cmd.do_fill ? srem_left : rem_r;
  assign snext_we    = cmd.rest_a || (cmd.rest_b && occ_r[plev]);
  assign snext_waddr = cmd.rest_a ? fptr_r : tail_q[SAW-1:0];
  assign snext_wdata = cmd.rest_a ? '0 : new_slot;

  lome_ram #(.WIDTH(SLOT_W), .DEPTH(NLEV)) u_head (
    .clk, .we(head_we), .waddr(lvl_waddr), .wdata(head_wdata),
    .raddr(lvl_raddr), .rdata(head_q));
  lome_ram #(.WIDTH(SLOT_W), .DEPTH(NLEV)) u_tail (
    .clk, .we(tail_we), .waddr(plev), .wdata(new_slot),
    .raddr(lvl_raddr), .rdata(tail_q));
  lome_ram #(.WIDTH(TOT_W), .DEPTH(NLEV)) u_total (
    .clk, .we(total_we), .waddr(lvl_waddr), .wdata(total_wdata),
    .raddr(lvl_raddr), .rdata(total_q));
  lome_ram #(.WIDTH(ID_W), .DEPTH(ORDER_SLOTS)) u_sid (
    .clk, .we(cmd.rest_a), .waddr(fptr_r), .wdata(id_r),
    .raddr(slot_raddr), .rdata(sid_q));
  lome_ram #(.WIDTH(QTY_W), .DEPTH(ORDER_SLOTS)) u_srem (
    .clk, .we(srem_we), .waddr(srem_waddr), .wdata(srem_wdata),
    .raddr(slot_raddr), .rdata(srem_q));
  lome_ram #(.WIDTH(SLOT_W), .DEPTH(ORDER_SLOTS)) u_snext (
    .clk, .we(snext_we), .waddr(snext_waddr), .wdata(snext_wdata),
    .raddr(slot_raddr), .rdata(snext_q));

  always_comb begin
    id_nxt    = accept ? in_order_id  : id_r;
    buy_nxt   = accept ? in_is_buy    : buy_r;
    lim_nxt   = accept ? in_is_limit  : lim_r;
    exec_nxt  = accept ? in_exec_kind : exec_r;
    price_nxt = accept ? in_price     : price_r;
    rem_nxt   = rem_r;
    if (accept) begin
      rem_nxt = in_quantity;
    end else if (cmd.do_fill) begin
      rem_nxt = rem_r - fq;
    end

    ptr_nxt = ptr_r;
    up_nxt  = up_r;
    if (cmd.ptr_init_fok) begin
      ptr_nxt = '0;
      up_nxt  = 1'b1;
    end else if (cmd.ptr_init_match) begin
      ptr_nxt = buy_r ? '0 : LW'(NLEV - 1);
      up_nxt  = buy_r;
    end else if (cmd.ptr_step) begin
      ptr_nxt = up_r ? (ptr_r + 1'b1) : (ptr_r - 1'b1);
    end

    // accumulate reachable liquidity one level behind the read
    qv_nxt  = cmd.fok_scan && qual;
    sum_nxt = accept ? '0 : (qv_r ? (sum_r + SUM_W'(total_q)) : sum_r);

    head_nxt  = cmd.hold_lvl ? head_q  : head_r;
    tail_nxt  = cmd.hold_lvl ? tail_q  : tail_r;
    total_nxt = cmd.hold_lvl ? total_q : total_r;

    fptr_nxt = fptr_r;
    if (cmd.fptr_clr) begin
      fptr_nxt = '0;
    end else if (cmd.fptr_step) begin
      fptr_nxt = fptr_r + 1'b1;
    end

    occ_nxt  = occ_r;
    side_nxt = side_r;
    free_nxt = free_r;
    if (cmd.do_fill && lvl_empty) begin
      occ_nxt[ptr_r] = 1'b0;
    end
    if (cmd.do_fill && emptied) begin
      free_nxt[head_idx] = 1'b1;
    end
    if (cmd.rest_a) begin
      free_nxt[fptr_r] = 1'b0;
    end
    if (cmd.rest_b && !occ_r[plev]) begin
      occ_nxt[plev]  = 1'b1;
      side_nxt[plev] = buy_r;
    end

    ov_nxt     = ov_r && !out_ready;
    okind_nxt  = okind_r;
    omaker_nxt = omaker_r;
    oqty_nxt   = oqty_r;
    oprice_nxt = oprice_r;
    orem_nxt   = orem_r;
    olast_nxt  = olast_r;
    if (cmd.do_fill) begin
      ov_nxt     = 1'b1;
      okind_nxt  = KIND_FILL;
      omaker_nxt = sid_q;
      oqty_nxt   = fq;
      oprice_nxt = ptr_ext;
      orem_nxt   = rem_r - fq;
      olast_nxt  = 1'b0;
    end else if (cmd.emit_final) begin
      ov_nxt     = 1'b1;
      okind_nxt  = cmd.final_kind;
      omaker_nxt = '0;
      oqty_nxt   = '0;
      oprice_nxt = '0;
      orem_nxt   = rem_r;
      olast_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r  <= '0;
      free_r <= '1;
      ov_r   <= 1'b0;
      qv_r   <= 1'b0;
    end else begin
      occ_r  <= occ_nxt;
      free_r <= free_nxt;
      ov_r   <= ov_nxt;
      qv_r   <= qv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r     <= id_nxt;
    buy_r    <= buy_nxt;
    lim_r    <= lim_nxt;
    exec_r   <= exec_nxt;
    price_r  <= price_nxt;
    rem_r    <= rem_nxt;
    ptr_r    <= ptr_nxt;
    up_r     <= up_nxt;
    sum_r    <= sum_nxt;
    head_r   <= head_nxt;
    tail_r   <= tail_nxt;
    total_r  <= total_nxt;
    fptr_r   <= fptr_nxt;
    side_r   <= side_nxt;
    okind_r  <= okind_nxt;
    omaker_r <= omaker_nxt;
    oqty_r   <= oqty_nxt;
    oprice_r <= oprice_nxt;
    orem_r   <= orem_nxt;
    olast_r  <= olast_nxt;
  end

  always_comb begin
    sts.in_valid  = in_valid;
    sts.reject    = !((exec_r == EXEC_GTC) || (exec_r == EXEC_IOC) || (exec_r == EXEC_FOK))
                    || (!lim_r && (exec_r == EXEC_GTC))
                    || (lim_r && (32'(price_r) >= 32'(PRICE_LEVELS)));
    sts.is_fok    = (exec_r == EXEC_FOK);
    sts.is_gtc    = (exec_r == EXEC_GTC);
    sts.rem_zero  = (rem_r == '0);
    sts.fok_short = (sum_r < SUM_W'(rem_r));
    sts.sc_hit    = occ_r[ptr_r] && (side_r[ptr_r] != buy_r);
    sts.cross_ok  = !lim_r || (buy_r ? (price_r >= ptr_ext) : (price_r <= ptr_ext));
    sts.ptr_end   = up_r ? (ptr_r == LW'(NLEV - 1)) : (ptr_r == '0);
    sts.fill_done = (rem_r <= srem_q);
    sts.free_hit  = free_r[fptr_r];
    sts.free_end  = (fptr_r == SAW'(ORDER_SLOTS - 1));
    sts.out_free  = out_free;
  end

  assign out_valid         = ov_r;
  assign out_kind          = okind_r;
  assign out_maker_id      = omaker_r;
  assign out_fill_quantity = oqty_r;
  assign out_fill_price    = oprice_r;
  assign out_remaining     = orem_r;
  assign out_last          = olast_r;
endmodule
`default_nettype wire

>>> sv/limit_order_matching_engine.sv
// Top level of the price-time priority order matching engine.
//
//  channel | direction | handshake           | carries
//  --------+-----------+---------------------+-------------------------------------------
//  in_     | into      | in_valid/in_ready   | one new order: id, side, type, exec, price, qty
//  out_    | out of    | out_valid/out_ready | one result: fill, or the order's final outcome
//
//  Flow: one order at a time, accepted in IDLE and checked in CHECK; fill-or-kill
//  adds one pass over the price levels (one level-total read each), then FOKW and FOKC.
//  Each fill runs the best-level scan, which steps one level per cycle from where
//  the previous fill left off, then HEAD and SLOT. Resting a remainder runs the
//  free-slot scan (one slot per cycle), then REST_A and REST_B.
//  Reset: synchronous, active low; occupancy and free-slot flags clear at once,
//  no memory clearing pass. A stalled result register holds the sequencer.
`default_nettype none
module limit_order_matching_engine #(
  parameter int PRICE_LEVELS = 256,
  parameter int ORDER_SLOTS  = 63
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [lome_pkg::ID_W-1:0]     in_order_id,
  input  wire logic                          in_is_buy,
  input  wire logic                          in_is_limit,
  input  wire logic [1:0]                    in_exec_kind,
  input  wire logic [lome_pkg::PRICE_W-1:0]  in_price,
  input  wire logic [lome_pkg::QTY_W-1:0]    in_quantity,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [2:0]                         out_kind,
  output logic [lome_pkg::ID_W-1:0]          out_maker_id,
  output logic [lome_pkg::QTY_W-1:0]         out_fill_quantity,
  output logic [lome_pkg::PRICE_W-1:0]       out_fill_price,
  output logic [lome_pkg::QTY_W-1:0]         out_remaining,
  output logic                               out_last
);
  import lome_pkg::*;

  lome_cmd_t cmd;
  lome_sts_t sts;

  // sequencer: decides each step, the datapath carries it out
  lome_ctrl u_ctrl (
    .clk, .rst_n, .sts, .cmd
  );

  // datapath: book memories, order registers and result register
  lome_dp #(.PRICE_LEVELS(PRICE_LEVELS), .ORDER_SLOTS(ORDER_SLOTS)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_valid, .in_order_id, .in_is_buy, .in_is_limit, .in_exec_kind,
    .in_price, .in_quantity,
    .out_valid, .out_ready, .out_kind, .out_maker_id, .out_fill_quantity,
    .out_fill_price, .out_remaining, .out_last
  );

  // take a new item only while the sequencer is idle
  assign in_ready = cmd.in_rdy;
endmodule
`default_nettype wire

>>> sv/lome_checker.sv
// Port-level checks of the matching engine and their binding to the top level.
`default_nettype none
`include "limit_order_matching_engine_defines.svh"
module lome_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [2:0]                    out_kind,
  input wire logic [lome_pkg::ID_W-1:0]     out_maker_id,
  input wire logic [lome_pkg::QTY_W-1:0]    out_fill_quantity,
  input wire logic [lome_pkg::PRICE_W-1:0]  out_fill_price,
  input wire logic [lome_pkg::QTY_W-1:0]    out_remaining,
  input wire logic                          out_last
);
  import lome_pkg::*;

  `LOME_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_remaining) && $stable(out_kind), "stalled result changed")
  `LOME_ASSERT_IMP(a_fill_not_last, out_valid && (out_kind == KIND_FILL), !out_last, "fill marked last")
  `LOME_ASSERT_IMP(a_final_last, out_valid && (out_kind != KIND_FILL), out_last, "final result not marked last")
  `LOME_ASSERT_IMP(a_fill_qty, out_valid && (out_kind == KIND_FILL), out_fill_quantity != '0, "empty fill")
  `LOME_ASSERT_IMP(a_final_zero, out_valid && (out_kind != KIND_FILL), (out_maker_id == '0) && (out_fill_quantity == '0) && (out_fill_price == '0), "final result carries fill fields")
endmodule

bind limit_order_matching_engine lome_checker u_lome_checker (.*);
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the price-time priority order matching engine.
`timescale 1ns / 100ps
`default_nettype none

// Scoreboard: an own copy of the order book that works out the results of each
// accepted order and checks the block's results against them in order.
class match_scoreboard;
  localparam int LEVELS = 256;
  localparam int SLOTS  = 63;

  typedef struct {
    lome_pkg::kind_t kind;
    logic [31:0]     maker;
    logic [31:0]     qty;
    logic [7:0]      price;
    logic [31:0]     rem;
    logic            last;
  } outcome_t;

  logic [31:0] rest_id   [SLOTS];
  logic [31:0] rest_qty  [SLOTS];
  logic [5:0]  rest_link [SLOTS];
  logic [62:0] free_map;
  logic [5:0]  lvl_head  [LEVELS];
  logic [5:0]  lvl_tail  [LEVELS];
  logic [37:0] lvl_sum   [LEVELS];
  bit          lvl_busy  [LEVELS];
  bit          lvl_buy   [LEVELS];

  outcome_t pending[$];
  int       errors;

  function new();
    free_map = '1;
    errors   = 0;
    for (int i = 0; i < LEVELS; i++) begin
      lvl_sum[i]  = '0;
      lvl_busy[i] = 0;
      lvl_buy[i]  = 0;
      lvl_head[i] = '0;
      lvl_tail[i] = '0;
    end
  endfunction

  function void push(lome_pkg::kind_t k, logic [31:0] m, logic [31:0] q,
                     logic [7:0] p, logic [31:0] r, logic l);
    outcome_t o;
    o.kind = k; o.maker = m; o.qty = q; o.price = p; o.rem = r; o.last = l;
    pending.push_back(o);
  endfunction

  function bit holds(int lv, bit buy_side);
    return lvl_busy[lv] && (lvl_buy[lv] == buy_side);
  endfunction

  function int best_of(bit buy_side);
    for (int i = 0; i < LEVELS; i++) begin
      int p;
      p = buy_side ? LEVELS - 1 - i : i;
      if (holds(p, buy_side)) return p;
    end
    return -1;
  endfunction

  // Work out every result of one accepted order and update the book.
  function void note_order(logic [31:0] id, bit buy, bit lim, logic [1:0] ex,
                           logic [7:0] price, logic [31:0] qty);
    logic [31:0] rem;
    logic [45:0] reach;
    int n, lv, s;
    logic [31:0] q;
    rem = qty;
    n   = 0;
    if (ex == 2'd3 || (!lim && ex == lome_pkg::EXEC_GTC)) begin
      push(lome_pkg::KIND_REJECTED, 0, 0, 0, rem, 1);
      return;
    end
    if (ex == lome_pkg::EXEC_FOK) begin
      reach = '0;
      for (int p = 0; p < LEVELS; p++)
        if (holds(p, !buy) && !(lim && (buy ? p > price : p < price)))
          reach += lvl_sum[p];
      if (reach < rem) begin
        push(lome_pkg::KIND_KILLED, 0, 0, 0, rem, 1);
        return;
      end
    end
    while (rem > 0 && n < 63) begin
      lv = best_of(!buy);
      if (lv < 0) break;
      if (lim && (buy ? price < lv : price > lv)) break;
      s = lvl_head[lv];
      q = rem < rest_qty[s] ? rem : rest_qty[s];
      rem -= q;
      rest_qty[s] -= q;
      lvl_sum[lv] -= q;
      push(lome_pkg::KIND_FILL, rest_id[s], q, lv[7:0], rem, 0);
      n++;
      if (rest_qty[s] == 0) begin
        if (lvl_tail[lv] == s) begin
          lvl_busy[lv] = 0;
          lvl_sum[lv]  = '0;
        end else begin
          lvl_head[lv] = rest_link[s];
        end
        free_map[s] = 1'b1;
      end
    end
    if (ex == lome_pkg::EXEC_GTC && rem > 0) begin
      if (free_map == '0) begin
        push(lome_pkg::KIND_FULL, 0, 0, 0, rem, 1);
        return;
      end
      for (s = 0; s < SLOTS; s++) if (free_map[s]) break;
      free_map[s]  = 1'b0;
      rest_id[s]   = id;
      rest_qty[s]  = rem;
      rest_link[s] = '0;
      if (lvl_busy[price]) begin
        rest_link[lvl_tail[price]] = s[5:0];
        lvl_tail[price] = s[5:0];
      end else begin
        lvl_head[price] = s[5:0];
        lvl_tail[price] = s[5:0];
        lvl_sum[price]  = '0;
        lvl_busy[price] = 1;
        lvl_buy[price]  = buy;
      end
      lvl_sum[price] += rem;
      push(lome_pkg::KIND_RESTED, 0, 0, 0, rem, 1);
      return;
    end
    push(lome_pkg::KIND_DONE, 0, 0, 0, rem, 1);
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Compare one accepted result with the oldest expectation.
  task automatic check_result(logic [2:0] k, logic [31:0] m, logic [31:0] q,
                              logic [7:0] p, logic [31:0] r, logic l);
    outcome_t o;
    if (pending.size() == 0) begin
      report("unexpected result kind", k, 0);
      return;
    end
    o = pending.pop_front();
    if (k !== o.kind)  report("kind", k, o.kind);
    if (m !== o.maker) report("maker_id", m, o.maker);
    if (q !== o.qty)   report("fill_quantity", q, o.qty);
    if (p !== o.price) report("fill_price", p, o.price);
    if (r !== o.rem)   report("remaining", r, o.rem);
    if (l !== o.last)  report("last", l, o.last);
  endtask
endclass

module testbench;
  import lome_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_order_id = '0;
  logic        in_is_buy = 1'b0;
  logic        in_is_limit = 1'b0;
  logic [1:0]  in_exec_kind = EXEC_GTC;
  logic [7:0]  in_price = '0;
  logic [31:0] in_quantity = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_kind;
  logic [31:0] out_maker_id, out_fill_quantity, out_remaining;
  logic [7:0]  out_fill_price;
  logic        out_last;

  match_scoreboard book_check = new();
  bit          stim_done = 0;
  logic [31:0] next_id = 32'd1;

  limit_order_matching_engine u_top (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Offer one order; hold it until the block takes it, then note it.
  // Drop valid only when idling, so valid gets one assignment per edge.
  task automatic send_order(bit buy, bit lim, logic [1:0] ex, logic [7:0] price,
                            logic [31:0] qty);
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_order_id  <= next_id;
    in_is_buy    <= buy;
    in_is_limit  <= lim;
    in_exec_kind <= ex;
    in_price     <= price;
    in_quantity  <= qty;
    do @(posedge clk); while (!in_ready);
    book_check.note_order(next_id, buy, lim, ex, price, qty);
    next_id = $urandom();
  endtask

  // Result side: draw a stall per item, sample at the edge.
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      book_check.check_result(out_kind, out_maker_id, out_fill_quantity, out_fill_price,
                              out_remaining, out_last);
    end
  end

  initial begin
    int mode;
    logic [31:0] q;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: market rest refused, undefined exec kind, zero quantity, extremes,
    // then a fill-or-kill short, a full fill-or-kill and a market sweep.
    send_order(1, 0, EXEC_GTC, 8'd10, 32'd5);
    send_order(0, 1, 2'd3, 8'd10, 32'd5);
    send_order(1, 1, EXEC_GTC, 8'd20, 32'd0);
    send_order(0, 1, EXEC_GTC, 8'd255, 32'hFFFF_FFFF);
    send_order(0, 1, EXEC_GTC, 8'd200, 32'd7);
    send_order(0, 1, EXEC_GTC, 8'd200, 32'd9);
    send_order(1, 1, EXEC_GTC, 8'd0, 32'd3);
    send_order(1, 1, EXEC_FOK, 8'd200, 32'd100);
    send_order(1, 1, EXEC_FOK, 8'd200, 32'd10);
    send_order(1, 1, EXEC_IOC, 8'd255, 32'd20);
    send_order(0, 0, EXEC_IOC, 8'd0, 32'd1);
    send_order(0, 0, EXEC_FOK, 8'hAA, 32'd2);
    send_order(1, 0, EXEC_IOC, 8'h55, 32'hFFFF_FFFF);
    send_order(0, 1, EXEC_IOC, 8'd0, 32'd4);
    // Fill the slot pool to reach the book-full case.
    for (int i = 0; i < 64; i++)
      send_order(1, 1, EXEC_GTC, 8'd1, 32'd1);
    send_order(0, 0, EXEC_IOC, 8'd0, 32'd100);

    // Random: mostly limit orders near a mid price so they cross and rest.
    for (int i = 0; i < 500; i++) begin
      mode = $urandom_range(0, 19);
      q = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(1, 40);
      if (mode == 0)
        send_order($urandom_range(0, 1), $urandom_range(0, 1), 2'($urandom_range(0, 3)),
                   8'($urandom()), $urandom_range(0, 5) == 0 ? 32'd0 : q);
      else if (mode < 3)
        send_order($urandom_range(0, 1), 0, 2'($urandom_range(1, 2)), 8'($urandom()), q);
      else
        send_order($urandom_range(0, 1), 1, 2'($urandom_range(0, 2)),
                   8'($urandom_range(118, 138)), q);
    end
    in_valid <= 1'b0;
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    wait (book_check.pending.size() == 0);
    repeat (400) @(posedge clk);
    if (book_check.errors == 0 && book_check.pending.size() == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

  initial begin
    #80ms;
    $display("testbench: done, errors");
    $finish;
  end
endmodule

`default_nettype wire
